// ===== rtl/rmq_pkg.sv =====
package rmq_pkg;

    localparam int ROT_W   = 16;
    localparam int FRAC_W  = ROT_W - 2;
    localparam int SHIFT_W = 32;
    localparam int QUO_W   = ROT_W + 1;
    localparam int SQ_W    = 2 * ROT_W;

    typedef logic signed [ROT_W-1:0]   t_rot;
    typedef logic signed [SHIFT_W-1:0] t_shift;
    typedef logic signed [ROT_W:0]     t_num;

    typedef struct packed {
        t_rot   rot_00;
        t_rot   rot_01;
        t_rot   rot_02;
        t_rot   rot_10;
        t_rot   rot_11;
        t_rot   rot_12;
        t_rot   rot_20;
        t_rot   rot_21;
        t_rot   rot_22;
        t_shift shift_x;
        t_shift shift_y;
        t_shift shift_z;
    } t_in;

    typedef struct packed {
        t_rot   quat_x;
        t_rot   quat_y;
        t_rot   quat_z;
        t_rot   quat_w;
        t_shift out_shift_x;
        t_shift out_shift_y;
        t_shift out_shift_z;
        logic   degenerate;
    } t_out;

    typedef enum logic [1:0] {
        BR_W = 2'd0,
        BR_X = 2'd1,
        BR_Y = 2'd2,
        BR_Z = 2'd3
    } t_branch;

    // Fields that ride along with every stage untouched.
    typedef struct packed {
        t_shift  sx;
        t_shift  sy;
        t_shift  sz;
        t_branch branch;
        logic    degen;
    } t_side;

    typedef struct packed {
        t_side            side;
        logic [ROT_W:0]   rad;
        t_num [2:0]       num;
    } t_front;

    typedef struct packed {
        t_side            side;
        t_num [2:0]       num;
        logic [ROT_W+1:0] rem;
        logic [ROT_W-1:0] res;
        logic [SQ_W-1:0]  rbits;
    } t_sq;

    typedef struct packed {
        t_side            side;
        t_num [2:0]       num;
        logic [ROT_W-1:0] root;
    } t_root;

    typedef struct packed {
        logic             neg;
        logic             ovf;
        logic [ROT_W-1:0] rem;
        logic [QUO_W-1:0] nb;
        logic [QUO_W-1:0] quo;
    } t_lane;

    typedef struct packed {
        t_side            side;
        logic [ROT_W-1:0] root;
        logic [ROT_W-1:0] big;
        t_lane [2:0]      lane;
    } t_dv;

endpackage

// ===== rtl/rmq_front.sv =====
module rmq_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    output logic            o_rdy,
    input  rmq_pkg::t_in    i_data,
    output logic            o_vld,
    input  logic            i_rdy,
    output rmq_pkg::t_front o_data
);
    import rmq_pkg::*;

    typedef logic signed [ROT_W+1:0] t_wide;

    function automatic t_wide ext2(t_rot v);
        return {{2{v[ROT_W-1]}}, v};
    endfunction

    function automatic t_num ext1(t_rot v);
        return {v[ROT_W-1], v};
    endfunction

    logic   r_vld;
    t_front r_st;
    t_front n_st;
    t_wide  trace;
    t_wide  rad_s;
    t_wide  one;

    assign one   = t_wide'(1) <<< FRAC_W;
    assign trace = ext2(i_data.rot_00) + ext2(i_data.rot_11) + ext2(i_data.rot_22);

    always_comb begin
        n_st.side.sx = i_data.shift_x;
        n_st.side.sy = i_data.shift_y;
        n_st.side.sz = i_data.shift_z;
        if (trace > 0) begin
            n_st.side.branch = BR_W;
            rad_s = one + trace;
            n_st.num[0] = ext1(i_data.rot_21) - ext1(i_data.rot_12);
            n_st.num[1] = ext1(i_data.rot_02) - ext1(i_data.rot_20);
            n_st.num[2] = ext1(i_data.rot_10) - ext1(i_data.rot_01);
        end else if (i_data.rot_00 > i_data.rot_11 && i_data.rot_00 > i_data.rot_22) begin
            n_st.side.branch = BR_X;
            rad_s = one + ext2(i_data.rot_00) - ext2(i_data.rot_11) - ext2(i_data.rot_22);
            n_st.num[0] = ext1(i_data.rot_21) - ext1(i_data.rot_12);
            n_st.num[1] = ext1(i_data.rot_01) + ext1(i_data.rot_10);
            n_st.num[2] = ext1(i_data.rot_02) + ext1(i_data.rot_20);
        end else if (i_data.rot_11 > i_data.rot_22) begin
            n_st.side.branch = BR_Y;
            rad_s = one + ext2(i_data.rot_11) - ext2(i_data.rot_00) - ext2(i_data.rot_22);
            n_st.num[0] = ext1(i_data.rot_02) - ext1(i_data.rot_20);
            n_st.num[1] = ext1(i_data.rot_01) + ext1(i_data.rot_10);
            n_st.num[2] = ext1(i_data.rot_12) + ext1(i_data.rot_21);
        end else begin
            n_st.side.branch = BR_Z;
            rad_s = one + ext2(i_data.rot_22) - ext2(i_data.rot_00) - ext2(i_data.rot_11);
            n_st.num[0] = ext1(i_data.rot_10) - ext1(i_data.rot_01);
            n_st.num[1] = ext1(i_data.rot_02) + ext1(i_data.rot_20);
            n_st.num[2] = ext1(i_data.rot_12) + ext1(i_data.rot_21);
        end
        // A degenerate item still flows through; a radicand of one keeps the root nonzero.
        n_st.side.degen = (rad_s <= 0);
        n_st.rad = n_st.side.degen ? (ROT_W+1)'(1) : rad_s[ROT_W:0];
    end

    assign o_rdy  = !r_vld || i_rdy;
    assign o_vld  = r_vld;
    assign o_data = r_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_st <= n_st;
        end
    end

endmodule

// ===== rtl/rmq_sqrt.sv =====
module rmq_sqrt (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    output logic            o_rdy,
    input  rmq_pkg::t_front i_data,
    output logic            o_vld,
    input  logic            i_rdy,
    output rmq_pkg::t_root  o_data
);
    import rmq_pkg::*;

    // One setup stage, then one result bit per stage.
    localparam int NST = ROT_W + 1;

    function automatic t_sq sq_step(t_sq s);
        t_sq              o;
        logic [ROT_W+1:0] cur;
        logic [ROT_W+1:0] trial;
        o     = s;
        cur   = {s.rem[ROT_W-1:0], s.rbits[SQ_W-1 -: 2]};
        trial = {s.res, 2'b01};
        if (cur >= trial) begin
            o.rem = cur - trial;
            o.res = {s.res[ROT_W-2:0], 1'b1};
        end else begin
            o.rem = cur;
            o.res = {s.res[ROT_W-2:0], 1'b0};
        end
        o.rbits = {s.rbits[SQ_W-3:0], 2'b00};
        return o;
    endfunction

    logic [NST-1:0] r_vld;
    logic [NST:0]   rdy;
    t_sq            r_st [NST];
    t_sq            n_st [NST];

    assign rdy[NST] = i_rdy;

    always_comb begin
        n_st[0].side  = i_data.side;
        n_st[0].num   = i_data.num;
        n_st[0].rem   = '0;
        n_st[0].res   = '0;
        n_st[0].rbits = {1'b0, i_data.rad, {FRAC_W{1'b0}}};
    end

    for (genvar k = 0; k < NST; k++) begin : g_st
        assign rdy[k] = !r_vld[k] || rdy[k+1];
        if (k > 0) begin : g_step
            assign n_st[k] = sq_step(r_st[k-1]);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (rdy[k]) begin
                r_vld[k] <= (k == 0) ? i_vld : r_vld[(k == 0) ? 0 : k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (rdy[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_rdy       = rdy[0];
    assign o_vld       = r_vld[NST-1];
    assign o_data.side = r_st[NST-1].side;
    assign o_data.num  = r_st[NST-1].num;
    assign o_data.root = r_st[NST-1].res;

endmodule

// ===== rtl/rmq_div.sv =====
module rmq_div (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_vld,
    output logic           o_rdy,
    input  rmq_pkg::t_root i_data,
    output logic           o_vld,
    input  logic           i_rdy,
    output rmq_pkg::t_out  o_data
);
    import rmq_pkg::*;

    // One setup stage, one quotient bit per stage.
    localparam int NST = QUO_W + 1;
    localparam int NUM_W = 2 * ROT_W - 1;

    function automatic t_lane lane_init(t_num num, logic [ROT_W-1:0] root);
        t_lane            o;
        logic [ROT_W:0]   mag;
        logic [NUM_W-1:0] dividend;
        logic [ROT_W-1:0] hi;
        o.neg    = num[ROT_W];
        mag      = o.neg ? (~num + 1'b1) : num;
        dividend = {mag, {FRAC_W{1'b0}}};
        hi       = {2'b00, dividend[NUM_W-1:QUO_W]};
        o.ovf    = (hi >= root);
        o.rem    = hi;
        o.nb     = dividend[QUO_W-1:0];
        o.quo    = '0;
        return o;
    endfunction

    function automatic t_lane lane_step(t_lane s, logic [ROT_W-1:0] root);
        t_lane          o;
        logic [ROT_W:0] t;
        o = s;
        t = {s.rem, s.nb[QUO_W-1]};
        if (t >= {1'b0, root}) begin
            o.rem = ROT_W'(t - {1'b0, root});
            o.quo = {s.quo[QUO_W-2:0], 1'b1};
        end else begin
            o.rem = t[ROT_W-1:0];
            o.quo = {s.quo[QUO_W-2:0], 1'b0};
        end
        o.nb = {s.nb[QUO_W-2:0], 1'b0};
        return o;
    endfunction

    // Round half away from zero on the magnitude, then saturate.
    function automatic t_rot lane_final(t_lane s);
        logic [QUO_W:0]   qq;
        logic [ROT_W:0]   q;
        logic [ROT_W:0]   lim;
        qq  = {1'b0, s.quo} + 1'b1;
        q   = qq[QUO_W:1];
        lim = (ROT_W+1)'(1) << (ROT_W - 1);
        if (s.ovf || q > lim) begin
            q = lim;
        end
        if (s.neg) begin
            return t_rot'(~q + 1'b1);
        end
        if (q == lim) begin
            q = lim - 1'b1;
        end
        return t_rot'(q);
    endfunction

    logic [NST:0]     r_vld;
    logic [NST+1:0]   rdy;
    t_dv              r_st [NST];
    t_dv              n_st [NST];
    t_out             r_out;
    t_out             n_out;
    logic [ROT_W:0]   rp1;
    t_rot             qa;
    t_rot             qb;
    t_rot             qc;
    t_rot             qbig;

    assign rp1 = {1'b0, i_data.root} + 1'b1;

    always_comb begin
        n_st[0].side = i_data.side;
        n_st[0].root = i_data.root;
        n_st[0].big  = rp1[ROT_W:1];
        for (int i = 0; i < 3; i++) begin
            n_st[0].lane[i] = lane_init(i_data.num[i], i_data.root);
        end
    end

    for (genvar k = 1; k < NST; k++) begin : g_step
        always_comb begin
            n_st[k] = r_st[k-1];
            for (int i = 0; i < 3; i++) begin
                n_st[k].lane[i] = lane_step(r_st[k-1].lane[i], r_st[k-1].root);
            end
        end
    end

    always_comb begin
        qa   = lane_final(r_st[NST-1].lane[0]);
        qb   = lane_final(r_st[NST-1].lane[1]);
        qc   = lane_final(r_st[NST-1].lane[2]);
        qbig = t_rot'(r_st[NST-1].big);
        n_out.out_shift_x = r_st[NST-1].side.sx;
        n_out.out_shift_y = r_st[NST-1].side.sy;
        n_out.out_shift_z = r_st[NST-1].side.sz;
        n_out.degenerate  = r_st[NST-1].side.degen;
        unique case (r_st[NST-1].side.branch)
            BR_W: begin
                n_out.quat_w = qbig; n_out.quat_x = qa;
                n_out.quat_y = qb;   n_out.quat_z = qc;
            end
            BR_X: begin
                n_out.quat_x = qbig; n_out.quat_w = qa;
                n_out.quat_y = qb;   n_out.quat_z = qc;
            end
            BR_Y: begin
                n_out.quat_y = qbig; n_out.quat_w = qa;
                n_out.quat_x = qb;   n_out.quat_z = qc;
            end
            default: begin
                n_out.quat_z = qbig; n_out.quat_w = qa;
                n_out.quat_x = qb;   n_out.quat_y = qc;
            end
        endcase
        if (r_st[NST-1].side.degen) begin
            n_out.quat_x = '0;
            n_out.quat_y = '0;
            n_out.quat_z = '0;
            n_out.quat_w = '0;
        end
    end

    assign rdy[NST+1] = i_rdy;

    for (genvar k = 0; k <= NST; k++) begin : g_vld
        assign rdy[k] = !r_vld[k] || rdy[k+1];
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (rdy[k]) begin
                r_vld[k] <= (k == 0) ? i_vld : r_vld[(k == 0) ? 0 : k-1];
            end
        end
    end

    for (genvar k = 0; k < NST; k++) begin : g_dat
        always_ff @(posedge i_clk) begin
            if (rdy[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[NST]) begin
            r_out <= n_out;
        end
    end

    assign o_rdy  = rdy[0];
    assign o_vld  = r_vld[NST];
    assign o_data = r_out;

endmodule

// ===== rtl/rotation_matrix_to_quaternion.sv =====
// Converts one rigid transform per transaction from a 3x3 rotation matrix in signed
// Q1.14 to a unit quaternion in signed Q1.14 by the trace method, and passes the
// Q16.16 translation through unchanged. A new transaction may enter every cycle
// while o_stall is low; each one passes through the pipeline: one stage for
// branch selection, 17 stages for the bit-per-stage square root and 19 stages
// for the three parallel bit-per-stage dividers with their rounding and output
// stage. A stall on the output holds the last stage, and the bubbles in front of
// it still fill, so the input side keeps accepting until the pipeline is full.
// When the selected radicand is not positive the quaternion is all zero and
// degenerate is set.
module rotation_matrix_to_quaternion (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  rmq_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output rmq_pkg::t_out o_data
);
    import rmq_pkg::*;

    logic   front_rdy;
    logic   front_vld;
    t_front front_data;
    logic   sqrt_rdy;
    logic   sqrt_vld;
    t_root  sqrt_data;
    logic   div_rdy;

    // Trace, branch choice, radicand and off-diagonal terms.
    rmq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_valid),
        .o_rdy   (front_rdy),
        .i_data  (i_data),
        .o_vld   (front_vld),
        .i_rdy   (sqrt_rdy),
        .o_data  (front_data)
    );

    // Integer square root of the radicand, one result bit per stage.
    rmq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (front_vld),
        .o_rdy   (sqrt_rdy),
        .i_data  (front_data),
        .o_vld   (sqrt_vld),
        .i_rdy   (div_rdy),
        .o_data  (sqrt_data)
    );

    // Three minor components divided by twice the root, then placed by branch.
    rmq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (sqrt_vld),
        .o_rdy   (div_rdy),
        .i_data  (sqrt_data),
        .o_vld   (o_valid),
        .i_rdy   (!i_stall),
        .o_data  (o_data)
    );

    assign o_stall = !front_rdy;

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import rmq_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RST_CYCLES  = 11;
    localparam int LATENCY     = 37;
    localparam int NUM_RANDOM  = 1750;
    localparam int IDLE_LIMIT  = 20000;
    localparam int HOLD_CYCLES = 300;
    localparam int MAX_REPORTS = 10;
    localparam int Q_MAX       = (1 << (ROT_W - 1)) - 1;
    localparam int Q_MIN       = -(1 << (ROT_W - 1));
    localparam int ONE         = 1 << FRAC_W;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    t_in  i_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    t_out o_data;

    always #CLK_HALF i_clk = ~i_clk;

    rotation_matrix_to_quaternion DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_data (i_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_data (o_data)
    );

    // Quaternions still owed by the block, oldest first.
    t_out pending_quats[$];
    int   mismatch_count = 0;
    int   sent_count = 0;
    int   recv_count = 0;
    int   degen_count = 0;
    int   idle_cycles = 0;
    bit   stim_done = 1'b0;
    bit   hold_output = 1'b0;
    int   branch_hits[4];

    // Bitwise integer square root, floor.
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // One off-diagonal term divided by twice the root, rounded half away from zero
    // and clamped to the output range.
    function automatic t_rot scaled_minor(longint num, longint unsigned root);
        bit              neg;
        longint unsigned mag;
        longint unsigned q;
        longint          r;
        neg = num < 0;
        mag = neg ? longint'(-num) : longint'(num);
        q   = (2 * (mag << (FRAC_W - 1)) + root) / (2 * root);
        r   = neg ? -longint'(q) : longint'(q);
        if (r > Q_MAX) r = Q_MAX;
        if (r < Q_MIN) r = Q_MIN;
        return t_rot'(r);
    endfunction

    function automatic t_out predict_quat(t_in d);
        t_out            q;
        longint          r00, r01, r02, r10, r11, r12, r20, r21, r22;
        longint          trace, rad, n1, n2, n3, big;
        longint unsigned root;
        t_branch         br;
        t_rot            a, b, c;
        r00 = d.rot_00; r01 = d.rot_01; r02 = d.rot_02;
        r10 = d.rot_10; r11 = d.rot_11; r12 = d.rot_12;
        r20 = d.rot_20; r21 = d.rot_21; r22 = d.rot_22;
        q = '0;
        q.out_shift_x = d.shift_x;
        q.out_shift_y = d.shift_y;
        q.out_shift_z = d.shift_z;
        trace = r00 + r11 + r22;
        if (trace > 0) begin
            br = BR_W; rad = ONE + trace;
            n1 = r21 - r12; n2 = r02 - r20; n3 = r10 - r01;
        end else if (r00 > r11 && r00 > r22) begin
            br = BR_X; rad = ONE + r00 - r11 - r22;
            n1 = r21 - r12; n2 = r01 + r10; n3 = r02 + r20;
        end else if (r11 > r22) begin
            br = BR_Y; rad = ONE + r11 - r00 - r22;
            n1 = r02 - r20; n2 = r01 + r10; n3 = r12 + r21;
        end else begin
            br = BR_Z; rad = ONE + r22 - r00 - r11;
            n1 = r10 - r01; n2 = r02 + r20; n3 = r12 + r21;
        end
        branch_hits[br]++;
        if (rad <= 0) begin
            q.degenerate = 1'b1;
            return q;
        end
        root = int_sqrt(longint'(rad) << FRAC_W);
        big  = longint'((root + 1) >> 1);
        if (big > Q_MAX) big = Q_MAX;
        a = scaled_minor(n1, root);
        b = scaled_minor(n2, root);
        c = scaled_minor(n3, root);
        case (br)
            BR_W: begin q.quat_w = t_rot'(big); q.quat_x = a; q.quat_y = b; q.quat_z = c; end
            BR_X: begin q.quat_x = t_rot'(big); q.quat_w = a; q.quat_y = b; q.quat_z = c; end
            BR_Y: begin q.quat_y = t_rot'(big); q.quat_w = a; q.quat_x = b; q.quat_z = c; end
            default: begin
                q.quat_z = t_rot'(big); q.quat_w = a; q.quat_x = b; q.quat_y = c;
            end
        endcase
        return q;
    endfunction

    function automatic t_rot pick_entry();
        case ($urandom_range(0, 5))
            0: return t_rot'(ONE);
            1: return t_rot'(-ONE);
            2: return t_rot'(0);
            3: return t_rot'($urandom_range(0, 2 * ONE) - ONE);
            default: return t_rot'($urandom);
        endcase
    endfunction

    // Mostly genuine rotations: signed axis permutations with some jitter, which
    // steer the trace to every branch. The rest mixes +-1, 0 and noise across the full range.
    function automatic t_in random_transform();
        t_in  d;
        t_rot m[9];
        int   perm[3];
        int   tmp, j, k;
        perm = '{0, 1, 2};
        for (j = 2; j > 0; j--) begin
            k = $urandom_range(0, j);
            tmp = perm[j]; perm[j] = perm[k]; perm[k] = tmp;
        end
        if ($urandom_range(0, 3) == 0) begin
            foreach (m[i]) m[i] = pick_entry();
        end else begin
            foreach (m[i]) m[i] = t_rot'(int'($urandom_range(0, 2000)) - 1000);
            for (j = 0; j < 3; j++)
                m[3 * j + perm[j]] = t_rot'(($urandom_range(0, 1) ? ONE : -ONE)
                                            + int'($urandom_range(0, 600)) - 300);
        end
        d = '{m[0], m[1], m[2], m[3], m[4], m[5], m[6], m[7], m[8],
              t_shift'($urandom), t_shift'($urandom), t_shift'($urandom)};
        return d;
    endfunction

    // Sends one transaction after a random gap and waits until the block takes it.
    // Valid stays high when the next transaction follows without a gap.
    task automatic send_transform(t_in d, int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= d;
        pending_quats.insert(pending_quats.size(), predict_quat(d));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_count++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_quats.size() != 0) @(posedge i_clk);
    endtask

    // Directed rows. Rows flagged as known carry an expected quaternion that can be
    // written down by hand; the others go through the predictor only.
    typedef struct {
        t_in  data;
        bit   known;
        t_rot qx, qy, qz, qw;
        bit   degen;
    } t_row;

    t_row directed[$];

    task automatic add_row(t_rot m00, t_rot m01, t_rot m02, t_rot m10, t_rot m11,
                           t_rot m12, t_rot m20, t_rot m21, t_rot m22, bit known,
                           t_rot qx = 0, t_rot qy = 0, t_rot qz = 0, t_rot qw = 0,
                           bit degen = 0);
        t_row r;
        r.data  = '{m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    t_shift'($urandom), t_shift'($urandom), t_shift'($urandom)};
        r.known = known;
        r.qx = qx; r.qy = qy; r.qz = qz; r.qw = qw; r.degen = degen;
        directed.insert(directed.size(), r);
    endtask

    task automatic build_directed();
        t_rot p, n, h;
        p = t_rot'(ONE);
        n = t_rot'(-ONE);
        h = t_rot'(ONE / 2);
        // Identity and the three half-turns, one per branch.
        add_row(p, 0, 0, 0, p, 0, 0, 0, p, 1, 0, 0, 0, p);
        add_row(p, 0, 0, 0, n, 0, 0, 0, n, 1, p, 0, 0, 0);
        add_row(n, 0, 0, 0, p, 0, 0, 0, n, 1, 0, p, 0, 0);
        add_row(n, 0, 0, 0, n, 0, 0, 0, p, 1, 0, 0, p, 0);
        // All-zero matrix falls to the z branch with a unit radicand.
        add_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, h, 0);
        // Mixed-sign diagonals that still leave a small positive trace.
        add_row(p, 0, 0, 0, p, 0, 0, 0, n, 0);
        add_row(t_rot'(Q_MAX), 0, 0, 0, t_rot'(Q_MAX), 0, 0, 0, t_rot'(Q_MIN), 0);
        // Ties on the diagonal.
        add_row(n, 0, 0, 0, n, 0, 0, 0, n, 0);
        add_row(0, 0, 0, 0, 0, 0, 0, 0, n, 0);
        add_row(0, 0, 0, 0, n, 0, 0, 0, 0, 0);
        add_row(t_rot'(-100), 0, 0, 0, t_rot'(-100), 0, 0, 0, t_rot'(-300), 0);
        // Extremes of every entry, small radicands and saturating minors.
        add_row(t_rot'(Q_MAX), t_rot'(Q_MAX), t_rot'(Q_MAX), t_rot'(Q_MAX),
                t_rot'(Q_MAX), t_rot'(Q_MAX), t_rot'(Q_MAX), t_rot'(Q_MAX),
                t_rot'(Q_MAX), 0);
        add_row(t_rot'(Q_MIN), t_rot'(Q_MIN), t_rot'(Q_MIN), t_rot'(Q_MIN),
                t_rot'(Q_MIN), t_rot'(Q_MIN), t_rot'(Q_MIN), t_rot'(Q_MIN),
                t_rot'(Q_MIN), 0);
        add_row(t_rot'(Q_MIN), t_rot'(Q_MAX), t_rot'(Q_MIN), t_rot'(Q_MAX),
                t_rot'(Q_MIN), t_rot'(Q_MAX), t_rot'(Q_MIN), t_rot'(Q_MAX),
                t_rot'(Q_MIN + 1), 0);
        add_row(t_rot'(1), t_rot'(Q_MIN), t_rot'(Q_MAX), t_rot'(Q_MAX), 0,
                t_rot'(Q_MIN), t_rot'(Q_MIN), t_rot'(Q_MAX), 0, 0);
        add_row(t_rot'(-ONE + 1), t_rot'(Q_MAX), 0, t_rot'(Q_MAX), t_rot'(-ONE), 0,
                0, 0, t_rot'(-ONE), 0);
        add_row(t_rot'(Q_MAX), t_rot'(Q_MIN), t_rot'(Q_MIN), t_rot'(Q_MIN),
                t_rot'(Q_MIN), t_rot'(Q_MAX), t_rot'(Q_MAX), t_rot'(Q_MAX),
                t_rot'(Q_MIN), 0);
        // A 90 degree turn about z.
        add_row(0, n, 0, p, 0, 0, 0, 0, p, 0);
    endtask

    // Stimulus process.
    initial begin
        t_out want;
        int   i;
        build_directed();
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed[r]) begin
            send_transform(directed[r].data, $urandom_range(0, 10));
            if (directed[r].known) begin
                // Replace the predicted entry with the hand-written one.
                want = pending_quats[$];
                want.quat_x = directed[r].qx;
                want.quat_y = directed[r].qy;
                want.quat_z = directed[r].qz;
                want.quat_w = directed[r].qw;
                want.degenerate = directed[r].degen;
                pending_quats[$] = want;
            end
        end
        // Pause the input until the pipeline has drained completely.
        wait_drained();
        for (i = 0; i < NUM_RANDOM; i++) begin
            if (i == NUM_RANDOM / 2) begin
                wait_drained();
            end
            // Streaks without gaps alternate with randomly spaced transactions.
            send_transform(random_transform(),
                           ((i / 100) % 3 == 0) ? 0 : $urandom_range(0, 10));
        end
        i_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // Output side: random stalls per transaction, one long hold-off that lets the
    // pipeline fill and push back on the input.
    initial begin
        int gap;
        i_stall <= 1'b1;
        @(posedge i_rst_n);
        forever begin
            if (hold_output) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_output = 1'b0;
            end
            gap = ((recv_count / 150) % 3 == 1) ? 0 : $urandom_range(0, 10);
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    // Trigger the long hold-off once the random stream is well under way.
    initial begin
        wait (sent_count == 400);
        hold_output = 1'b1;
    end

    // Result checker: compare every accepted transaction with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            recv_count <= recv_count + 1;
            if (o_data.degenerate) degen_count <= degen_count + 1;
            if (pending_quats.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: %p", o_data);
            end else begin
                t_out want;
                want = pending_quats.pop_front();
                if (o_data !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("mismatch at result %0d", recv_count);
                        $display("  expected x=%0d y=%0d z=%0d w=%0d deg=%0b sh=%h %h %h",
                                 want.quat_x, want.quat_y, want.quat_z, want.quat_w,
                                 want.degenerate, want.out_shift_x, want.out_shift_y,
                                 want.out_shift_z);
                        $display("  actual   x=%0d y=%0d z=%0d w=%0d deg=%0b sh=%h %h %h",
                                 o_data.quat_x, o_data.quat_y, o_data.quat_z,
                                 o_data.quat_w, o_data.degenerate, o_data.out_shift_x,
                                 o_data.out_shift_y, o_data.out_shift_z);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transaction on either side.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // End of run.
    initial begin
        fork
            begin
                wait (stim_done);
                while (pending_quats.size() != 0) @(posedge i_clk);
                repeat (2 * LATENCY) @(posedge i_clk);
                $display("Sent %0d transforms, %0d quaternions returned, %0d degenerate.",
                         sent_count, recv_count, degen_count);
                $display("Branch hits w/x/y/z: %0d %0d %0d %0d.", branch_hits[0],
                         branch_hits[1], branch_hits[2], branch_hits[3]);
                if (mismatch_count == 0 && pending_quats.size() == 0)
                    $display("rotation_matrix_to_quaternion test passed");
                else
                    $display("rotation_matrix_to_quaternion test failed");
            end
            begin
                wait (idle_cycles >= IDLE_LIMIT);
                $display("Watchdog expired with %0d results outstanding.",
                         pending_quats.size());
                $display("rotation_matrix_to_quaternion test failed");
            end
        join_any
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rmq_pkg.sv
rtl/rmq_front.sv
rtl/rmq_sqrt.sv
rtl/rmq_div.sv
rtl/rotation_matrix_to_quaternion.sv
dv/tb_top.sv
